[rtl/core/tracker_sighting_table_defines.svh]
// ----------------------------------------------------------------------------
// Tracker sighting table: shared assertion macros
// Concurrent check helpers; the using module must have clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef TRACKER_SIGHTING_TABLE_DEFINES_SVH
`define TRACKER_SIGHTING_TABLE_DEFINES_SVH

// same-cycle implication
`define TST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker sighting table package
// Codes, constants and the structs shared by the table modules.
// ----------------------------------------------------------------------------
package tst_pkg;

    // request op codes
    localparam logic [1:0] OP_REPORT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // tag kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_FINDER  = 2'd1;
    localparam logic [1:0] KIND_COMPANY = 2'd2;
    localparam logic [1:0] KIND_SERVICE = 2'd3;

    // result outcomes
    localparam logic [2:0] OUT_IGNORED  = 3'd0;
    localparam logic [2:0] OUT_UPDATED  = 3'd1;
    localparam logic [2:0] OUT_INSERTED = 3'd2;
    localparam logic [2:0] OUT_FULL     = 3'd3;
    localparam logic [2:0] OUT_LOCK_HIT = 3'd4;
    localparam logic [2:0] OUT_DONE     = 3'd5;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCATE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_ADDRESS = 2'd1;

    // classification constants
    localparam logic [15:0] COMPANY_FINDER  = 16'h004C;
    localparam logic [7:0]  TYPE_FINDER     = 8'h12;
    localparam logic [15:0] COMPANY_OTHER   = 16'h0075;

    localparam logic signed [7:0] NO_SIGNAL = 8'sh9C;   // -100 dBm

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_DONE
    } tst_state_t;

    typedef struct packed {
        logic [47:0]        address;
        logic [1:0]         kind;
        logic signed [7:0]  strength;
        logic signed [7:0]  best;
        logic [31:0]        last_ms;
    } tst_entry_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [47:0]        address;
        logic signed [7:0]  strength;
        logic [31:0]        now_ms;
        logic [1:0]         kind;
        logic               locate;
        logic               lock_hit;
        logic [3:0]         read_index;
    } tst_req_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         outcome;
        logic [3:0]         slot;
        logic [4:0]         entry_count;
        logic               slot_valid;
        logic [47:0]        slot_address;
        logic signed [7:0]  slot_strength;
        logic signed [7:0]  slot_best;
        logic [31:0]        slot_last_ms;
        logic signed [7:0]  lock_strength;
        logic [31:0]        lock_last_ms;
    } tst_res_t;

endpackage

[rtl/core/tst_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/tst_engine.sv]
`timescale 1ns / 1ps
`include "tracker_sighting_table_defines.svh"
// ----------------------------------------------------------------------------
// Tracker sighting table engine
// Sequencer over the entry RAM: linear search, update or append, read, clear,
// plus the entry count and the locked-address reading.
// ----------------------------------------------------------------------------
module tst_engine #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  tst_pkg::tst_req_t  req,
    output logic               res_valid,
    input  logic               out_free,
    output tst_pkg::tst_res_t  res
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
    localparam int unsigned EW    = $bits(tst_pkg::tst_entry_t);

    tst_pkg::tst_state_t state_reg, state_next;
    tst_pkg::tst_req_t   req_reg, req_next;
    tst_pkg::tst_res_t   res_reg, res_next;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic signed [7:0]   lock_strength_reg, lock_strength_next;
    logic [31:0]         lock_time_reg, lock_time_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    tst_pkg::tst_entry_t ram_wdata;
    tst_pkg::tst_entry_t ram_rdata;
    logic [EW-1:0]       ram_rdata_raw;

    logic                issue_en;
    logic                hit;
    logic                miss;
    logic                full;
    logic                do_insert;
    logic                rd_ok;
    logic signed [7:0]   best_new;

    tst_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = tst_pkg::tst_entry_t'(ram_rdata_raw);

    // search pipeline: issue one address a cycle, compare the one issued before
    assign issue_en  = (ptr_reg < count_reg);
    assign hit       = chk_vld_reg && (ram_rdata.address == req_reg.address);
    assign miss      = !issue_en && !chk_vld_reg;
    assign full      = (32'(count_reg) >= ENTRIES);
    assign do_insert = (state_reg == tst_pkg::ST_SCAN) && miss && !full;
    assign rd_ok     = (32'(req_reg.read_index) < 32'(count_reg)) &&
                       (32'(req_reg.read_index) < ENTRIES);
    assign best_new  = (req_reg.strength > ram_rdata.best) ? req_reg.strength
                                                           : ram_rdata.best;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= tst_pkg::ST_IDLE;
            count_reg         <= '0;
            chk_vld_reg       <= 1'b0;
            lock_strength_reg <= tst_pkg::NO_SIGNAL;
            lock_time_reg     <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            chk_vld_reg       <= chk_vld_next;
            lock_strength_reg <= lock_strength_next;
            lock_time_reg     <= lock_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        res_reg     <= res_next;
        ptr_reg     <= ptr_next;
        chk_idx_reg <= chk_idx_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tst_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.op)
                        tst_pkg::OP_REPORT:
                        begin
                            if (!req.locate && (req.kind != tst_pkg::KIND_NONE))
                            begin
                                state_next = tst_pkg::ST_SCAN;
                            end
                            else
                            begin
                                state_next = tst_pkg::ST_DONE;
                            end
                        end
                        tst_pkg::OP_READ: state_next = tst_pkg::ST_RD_ADDR;
                        default:          state_next = tst_pkg::ST_DONE;
                    endcase
                end
            end
            tst_pkg::ST_SCAN:
            begin
                if (hit || miss)
                begin
                    state_next = tst_pkg::ST_DONE;
                end
            end
            tst_pkg::ST_RD_ADDR: state_next = tst_pkg::ST_RD_DATA;
            tst_pkg::ST_RD_DATA: state_next = tst_pkg::ST_DONE;
            tst_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tst_pkg::ST_IDLE;
                end
            end
            default: state_next = tst_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next           = req_reg;
        res_next           = res_reg;
        count_next         = count_reg;
        ptr_next           = ptr_reg;
        chk_vld_next       = 1'b0;
        chk_idx_next       = chk_idx_reg;
        lock_strength_next = lock_strength_reg;
        lock_time_next     = lock_time_reg;
        ram_we             = 1'b0;
        ram_waddr          = chk_idx_reg;
        ram_wdata          = ram_rdata;
        ram_raddr          = ptr_reg[IDX_W-1:0];
        req_ready          = 1'b0;
        res_valid          = 1'b0;

        unique case (state_reg)
            tst_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next = req;
                    ptr_next = '0;
                    res_next = '0;
                    case (req.op)
                        tst_pkg::OP_REPORT:
                        begin
                            res_next.kind = req.kind;
                            if (req.locate)
                            begin
                                if (req.lock_hit)
                                begin
                                    lock_strength_next = req.strength;
                                    lock_time_next     = req.now_ms;
                                    res_next.outcome   = tst_pkg::OUT_LOCK_HIT;
                                end
                            end
                        end
                        tst_pkg::OP_CLEAR:
                        begin
                            count_next         = '0;
                            lock_strength_next = tst_pkg::NO_SIGNAL;
                            lock_time_next     = '0;
                            res_next.outcome   = tst_pkg::OUT_DONE;
                        end
                        default:
                        begin
                            res_next.outcome = tst_pkg::OUT_IGNORED;
                        end
                    endcase
                end
            end
            tst_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    // keep address and stored kind, refresh the reading
                    ram_we                 = 1'b1;
                    ram_waddr              = chk_idx_reg;
                    ram_wdata.address      = ram_rdata.address;
                    ram_wdata.kind         = ram_rdata.kind;
                    ram_wdata.strength     = req_reg.strength;
                    ram_wdata.best         = best_new;
                    ram_wdata.last_ms      = req_reg.now_ms;
                    res_next.outcome       = tst_pkg::OUT_UPDATED;
                    res_next.slot          = 4'(chk_idx_reg);
                    res_next.slot_valid    = 1'b1;
                    res_next.slot_address  = ram_rdata.address;
                    res_next.slot_strength = req_reg.strength;
                    res_next.slot_best     = best_new;
                    res_next.slot_last_ms  = req_reg.now_ms;
                end
                else if (miss)
                begin
                    if (full)
                    begin
                        res_next.outcome = tst_pkg::OUT_FULL;
                    end
                    else
                    begin
                        // append at the end of the table
                        ram_we                 = 1'b1;
                        ram_waddr              = count_reg[IDX_W-1:0];
                        ram_wdata.address      = req_reg.address;
                        ram_wdata.kind         = req_reg.kind;
                        ram_wdata.strength     = req_reg.strength;
                        ram_wdata.best         = req_reg.strength;
                        ram_wdata.last_ms      = req_reg.now_ms;
                        count_next             = count_reg + 1'b1;
                        res_next.outcome       = tst_pkg::OUT_INSERTED;
                        res_next.slot          = 4'(count_reg);
                        res_next.slot_valid    = 1'b1;
                        res_next.slot_address  = req_reg.address;
                        res_next.slot_strength = req_reg.strength;
                        res_next.slot_best     = req_reg.strength;
                        res_next.slot_last_ms  = req_reg.now_ms;
                    end
                end
                else
                begin
                    chk_vld_next = issue_en;
                    chk_idx_next = ptr_reg[IDX_W-1:0];
                    if (issue_en)
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            tst_pkg::ST_RD_ADDR:
            begin
                ram_raddr = IDX_W'(req_reg.read_index);
            end
            tst_pkg::ST_RD_DATA:
            begin
                res_next.outcome = tst_pkg::OUT_DONE;
                res_next.slot    = req_reg.read_index;
                if (rd_ok)
                begin
                    res_next.kind          = ram_rdata.kind;
                    res_next.slot_valid    = 1'b1;
                    res_next.slot_address  = ram_rdata.address;
                    res_next.slot_strength = ram_rdata.strength;
                    res_next.slot_best     = ram_rdata.best;
                    res_next.slot_last_ms  = ram_rdata.last_ms;
                end
            end
            tst_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // count and lock reading are already final while the result waits
    always_comb
    begin
        res               = res_reg;
        res.entry_count   = 5'(count_reg);
        res.lock_strength = lock_strength_reg;
        res.lock_last_ms  = lock_time_reg;
    end

    `TST_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_reg) <= ENTRIES, "entry count above depth")
    `TST_ASSERT_NOW(a_write_scan, ram_we, (state_reg == tst_pkg::ST_SCAN) && (hit || do_insert), "table write outside search end")
    `TST_ASSERT_NEXT(a_insert_count, do_insert, count_reg == $past(count_reg) + 1'b1, "append did not advance count")
    `TST_ASSERT_NEXT(a_clear, req_valid && (state_reg == tst_pkg::ST_IDLE) && (req.op == tst_pkg::OP_CLEAR), (count_reg == '0) && (lock_strength_reg == tst_pkg::NO_SIGNAL), "clear left state behind")

endmodule

[rtl/core/tracker_sighting_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker sighting table
// Classifies advertisement reports into tag kinds and keeps a table of sighted
// tags with latest and best strength, or follows one locked address.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   in       | in_valid / in_ready  | op, address, strength, now_ms, ...
//   out      | out_valid / out_ready| kind, outcome, slot, entry_count, ...
//   cfg      | cfg_write            | cfg_index, cfg_data (no read-back)
//
// A report of a known kind outside locate mode searches the entry RAM one entry
// a cycle until it meets its address or passes the last entry. A read addresses
// the RAM, then takes its data; any other request goes straight to its result.
// Each result shows in the same cycle that the next request can be taken. One
// request is in work at a time. Reset empties the table by count; the RAM itself
// is not cleared. A stalled result holds in the output register; the next request
// is taken while it waits, and its own result then waits for the register to free.
// ----------------------------------------------------------------------------
module tracker_sighting_table #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_write,
    input  logic [tst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [47:0]                        cfg_data,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         op,
    input  logic [47:0]                        address,
    input  logic signed [7:0]                  strength,
    input  logic [31:0]                        now_ms,
    input  logic                               maker_data_ok,
    input  logic [15:0]                        company_id,
    input  logic [7:0]                         maker_type,
    input  logic                               tag_service_seen,
    input  logic [3:0]                         read_index,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         kind,
    output logic [2:0]                         outcome,
    output logic [3:0]                         slot,
    output logic [4:0]                         entry_count,
    output logic                               slot_valid,
    output logic [47:0]                        slot_address,
    output logic signed [7:0]                  slot_strength,
    output logic signed [7:0]                  slot_best,
    output logic [31:0]                        slot_last_ms,
    output logic signed [7:0]                  lock_strength,
    output logic [31:0]                        lock_last_ms
);

    logic               locate_mode_reg, locate_mode_next;
    logic [47:0]        lock_address_reg, lock_address_next;
    logic               out_valid_reg, out_valid_next;
    tst_pkg::tst_res_t  out_reg, out_next;

    tst_pkg::tst_req_t  req;
    tst_pkg::tst_res_t  res;
    logic               res_valid;
    logic               out_free;
    logic [1:0]         class_kind;

    // configuration writes
    always_comb
    begin
        locate_mode_next  = locate_mode_reg;
        lock_address_next = lock_address_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                tst_pkg::REG_LOCATE_MODE:  locate_mode_next  = cfg_data[0];
                tst_pkg::REG_LOCK_ADDRESS: lock_address_next = cfg_data;
                default:                   locate_mode_next  = locate_mode_reg;
            endcase
        end
    end

    // kind priority: finder company and type, then other company, then service
    always_comb
    begin
        if (maker_data_ok && (company_id == tst_pkg::COMPANY_FINDER) &&
            (maker_type == tst_pkg::TYPE_FINDER))
        begin
            class_kind = tst_pkg::KIND_FINDER;
        end
        else if (maker_data_ok && (company_id == tst_pkg::COMPANY_OTHER))
        begin
            class_kind = tst_pkg::KIND_COMPANY;
        end
        else if (tag_service_seen)
        begin
            class_kind = tst_pkg::KIND_SERVICE;
        end
        else
        begin
            class_kind = tst_pkg::KIND_NONE;
        end
    end

    always_comb
    begin
        req.op         = op;
        req.address    = address;
        req.strength   = strength;
        req.now_ms     = now_ms;
        req.kind       = class_kind;
        req.locate     = locate_mode_reg;
        req.lock_hit   = (address == lock_address_reg);
        req.read_index = read_index;
    end

    tst_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req       (req),
        .res_valid (res_valid),
        .out_free  (out_free),
        .res       (res)
    );

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid && out_free)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locate_mode_reg  <= 1'b0;
            lock_address_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            locate_mode_reg  <= locate_mode_next;
            lock_address_reg <= lock_address_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign outcome       = out_reg.outcome;
    assign slot          = out_reg.slot;
    assign entry_count   = out_reg.entry_count;
    assign slot_valid    = out_reg.slot_valid;
    assign slot_address  = out_reg.slot_address;
    assign slot_strength = out_reg.slot_strength;
    assign slot_best     = out_reg.slot_best;
    assign slot_last_ms  = out_reg.slot_last_ms;
    assign lock_strength = out_reg.lock_strength;
    assign lock_last_ms  = out_reg.lock_last_ms;

endmodule
